FILE: design/utf8pn_pkg.sv
// ============================================================================
// utf8pn_pkg: shared types, constants and helper functions
// Punctuation folding and whitespace trimming for a UTF-8 byte stream.
// ============================================================================
package utf8pn_pkg;

	// held whitespace run
	localparam int RUN_DEPTH = 16;
	localparam int RUN_CNT_W = $clog2(RUN_DEPTH + 1);
	localparam int RUN_IDX_W = (RUN_DEPTH > 1) ? $clog2(RUN_DEPTH) : 1;

	// byte codes
	localparam logic [7:0] LEAD_E2    = 8'hE2;
	localparam logic [7:0] LEAD_C2    = 8'hC2;
	localparam logic [7:0] CONT_80    = 8'h80;
	localparam logic [7:0] CONT_88    = 8'h88;
	localparam logic [7:0] LSQUO      = 8'h98;
	localparam logic [7:0] RSQUO      = 8'h99;
	localparam logic [7:0] PRIME      = 8'hB2;
	localparam logic [7:0] LDQUO      = 8'h9C;
	localparam logic [7:0] RDQUO      = 8'h9D;
	localparam logic [7:0] EMDASH     = 8'h94;
	localparam logic [7:0] ENDASH     = 8'h93;
	localparam logic [7:0] MINUS_LO   = 8'h92;
	localparam logic [7:0] NBSP_LO    = 8'hA0;
	localparam logic [7:0] CH_APOS    = 8'h27;
	localparam logic [7:0] CH_DQUOTE  = 8'h22;
	localparam logic [7:0] CH_HYPHEN  = 8'h2D;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_LF      = 8'h0A;

	// whitespace codes held in the run
	localparam logic [1:0] WS_SPACE = 2'd0;
	localparam logic [1:0] WS_TAB   = 2'd1;
	localparam logic [1:0] WS_CR    = 2'd2;
	localparam logic [1:0] WS_LF    = 2'd3;

	typedef enum logic [1:0] {
		ST_PARSE,
		ST_FLUSH,
		ST_END
	} state_t;

	typedef enum logic [2:0] {
		EM_NONE,
		EM_SYM,
		EM_RUN,
		EM_OVF,
		EM_END
	} emit_t;

	typedef struct packed {
		logic  load;
		logic  advance;
		logic  run_push;
		logic  run_pop;
		logic  clear;
		emit_t emit;
	} cmd_t;

	typedef struct packed {
		logic done;
		logic last;
		logic drop;
		logic is_ws;
		logic run_full;
		logic run_empty;
		logic run_one;
		logic slot_free;
	} stat_t;

	// replacement for E2 c1 c2, zero when not a listed sequence
	function automatic logic [7:0] triple_map(input logic [7:0] c1, input logic [7:0] c2);
		logic [7:0] r;
		r = 8'h00;
		if (c1 == CONT_80) begin
			if (c2 == LSQUO || c2 == RSQUO || c2 == PRIME)
				r = CH_APOS;
			else if (c2 == LDQUO || c2 == RDQUO)
				r = CH_DQUOTE;
			else if (c2 == EMDASH || c2 == ENDASH)
				r = CH_HYPHEN;
		end
		if (c1 == CONT_88 && c2 == MINUS_LO)
			r = CH_HYPHEN;
		return r;
	endfunction

	function automatic logic is_letter(input logic [7:0] b);
		return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
	endfunction

	// {valid, code}
	function automatic logic [2:0] ws_code(input logic [7:0] b);
		logic [2:0] r;
		case (b)
			CH_SPACE: r = {1'b1, WS_SPACE};
			CH_TAB:   r = {1'b1, WS_TAB};
			CH_CR:    r = {1'b1, WS_CR};
			CH_LF:    r = {1'b1, WS_LF};
			default:  r = 3'b000;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] ws_char(input logic [1:0] code);
		logic [7:0] r;
		unique case (code)
			WS_SPACE: r = CH_SPACE;
			WS_TAB:   r = CH_TAB;
			WS_CR:    r = CH_CR;
			WS_LF:    r = CH_LF;
			default:  r = CH_SPACE;
		endcase
		return r;
	endfunction

endpackage

FILE: design/utf8pn_ctrl.sv
// ============================================================================
// utf8pn_ctrl: sequencing state machine
// Steps the parser through the byte buffer, flushes held whitespace and
// issues the end marker; drives the datapath by command struct.
// ============================================================================
module utf8pn_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  utf8pn_pkg::stat_t  stat,
	output utf8pn_pkg::cmd_t   cmd
);

	utf8pn_pkg::state_t state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= utf8pn_pkg::ST_PARSE;
		else
			state_q <= state_n;
	end

	always_comb begin
		state_n      = state_q;
		s_tready     = 1'b0;
		cmd.load     = 1'b0;
		cmd.advance  = 1'b0;
		cmd.run_push = 1'b0;
		cmd.run_pop  = 1'b0;
		cmd.clear    = 1'b0;
		cmd.emit     = utf8pn_pkg::EM_NONE;
		unique case (state_q)
			utf8pn_pkg::ST_PARSE: begin
				if (stat.done) begin
					if (stat.last) begin
						state_n = utf8pn_pkg::ST_END;
					end else begin
						s_tready = 1'b1;
						cmd.load = s_tvalid;
					end
				end else if (stat.drop) begin
					cmd.advance = 1'b1;
				end else if (stat.is_ws) begin
					if (!stat.run_full) begin
						cmd.run_push = 1'b1;
						cmd.advance  = 1'b1;
					end else if (stat.slot_free) begin
						// run full: oldest byte goes out flagged
						cmd.emit     = utf8pn_pkg::EM_OVF;
						cmd.run_pop  = 1'b1;
						cmd.run_push = 1'b1;
						cmd.advance  = 1'b1;
					end
				end else if (!stat.run_empty) begin
					state_n = utf8pn_pkg::ST_FLUSH;
				end else if (stat.slot_free) begin
					cmd.emit    = utf8pn_pkg::EM_SYM;
					cmd.advance = 1'b1;
				end
			end
			utf8pn_pkg::ST_FLUSH: begin
				if (stat.slot_free) begin
					cmd.emit    = utf8pn_pkg::EM_RUN;
					cmd.run_pop = 1'b1;
					if (stat.run_one)
						state_n = utf8pn_pkg::ST_PARSE;
				end
			end
			utf8pn_pkg::ST_END: begin
				if (stat.slot_free) begin
					cmd.emit  = utf8pn_pkg::EM_END;
					cmd.clear = 1'b1;
					state_n   = utf8pn_pkg::ST_PARSE;
				end
			end
			default: state_n = utf8pn_pkg::ST_PARSE;
		endcase
	end

endmodule

FILE: design/utf8pn_dp.sv
// ============================================================================
// utf8pn_dp: byte buffer, sequence matcher, whitespace run and output register
// Holds up to three bytes under examination and the held whitespace run.
// ============================================================================
module utf8pn_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  utf8pn_pkg::cmd_t   cmd,
	output utf8pn_pkg::stat_t  stat,
	input  logic [7:0]         in_byte,
	input  logic               in_last,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         out_byte,
	output logic               out_has,
	output logic               out_last,
	output logic               out_ovf
);

	localparam logic [utf8pn_pkg::RUN_CNT_W-1:0] RUN_FULL =
		utf8pn_pkg::RUN_CNT_W'(utf8pn_pkg::RUN_DEPTH);
	localparam logic [utf8pn_pkg::RUN_IDX_W-1:0] RUN_TOP =
		utf8pn_pkg::RUN_IDX_W'(utf8pn_pkg::RUN_DEPTH - 1);

	logic [7:0] buf_q [3];
	logic [1:0] cnt_q, pos_q;
	logic       last_q, lead_q;
	logic [1:0] run_q [utf8pn_pkg::RUN_DEPTH];
	logic [utf8pn_pkg::RUN_CNT_W-1:0] run_cnt_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_has_q, out_last_q, out_ovf_q;

	logic [7:0] sh0, sh1, sh2, map, sym;
	logic [1:0] rem, adv;
	logic       is_e2, is_c2, brk;
	logic [2:0] ws;
	logic [7:0] buf_n [3];
	logic [utf8pn_pkg::RUN_IDX_W-1:0] push_idx;

	// bytes from the current position on
	always_comb begin
		unique case (pos_q)
			2'd0: begin sh0 = buf_q[0]; sh1 = buf_q[1]; sh2 = buf_q[2]; end
			2'd1: begin sh0 = buf_q[1]; sh1 = buf_q[2]; sh2 = 8'h00;    end
			2'd2: begin sh0 = buf_q[2]; sh1 = 8'h00;    sh2 = 8'h00;    end
			default: begin sh0 = 8'h00; sh1 = 8'h00;    sh2 = 8'h00;    end
		endcase
	end

	assign rem   = cnt_q - pos_q;
	assign map   = utf8pn_pkg::triple_map(sh1, sh2);
	assign is_e2 = (sh0 == utf8pn_pkg::LEAD_E2);
	assign is_c2 = (sh0 == utf8pn_pkg::LEAD_C2);
	// a lead byte waits for more input unless the stream ends here
	assign brk   = !last_q && ((is_e2 && rem < 2'd3) || (is_c2 && rem < 2'd2));

	always_comb begin
		if (is_e2 && rem == 2'd3 && map != 8'h00) begin
			sym = map;
			adv = 2'd3;
		end else if (is_c2 && rem >= 2'd2 && sh1 == utf8pn_pkg::NBSP_LO) begin
			sym = utf8pn_pkg::CH_SPACE;
			adv = 2'd2;
		end else begin
			sym = sh0;
			adv = 2'd1;
		end
	end

	assign ws = utf8pn_pkg::ws_code(sym);

	assign stat.done      = (rem == 2'd0) || brk;
	assign stat.last      = last_q;
	assign stat.drop      = lead_q && !sym[7] && !utf8pn_pkg::is_letter(sym);
	assign stat.is_ws     = ws[2];
	assign stat.run_full  = (run_cnt_q == RUN_FULL);
	assign stat.run_empty = (run_cnt_q == '0);
	assign stat.run_one   = (run_cnt_q == utf8pn_pkg::RUN_CNT_W'(1));
	assign stat.slot_free = !out_valid_q || out_ready;

	// leftover bytes move to the front, the new byte goes behind them
	always_comb begin
		buf_n[0] = (rem > 2'd0) ? sh0 : in_byte;
		buf_n[1] = (rem > 2'd1) ? sh1 : in_byte;
		buf_n[2] = in_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= 2'd0;
			pos_q  <= 2'd0;
			last_q <= 1'b0;
			lead_q <= 1'b1;
		end else if (cmd.clear) begin
			cnt_q  <= 2'd0;
			pos_q  <= 2'd0;
			last_q <= 1'b0;
			lead_q <= 1'b1;
		end else if (cmd.load) begin
			cnt_q  <= rem + 2'd1;
			pos_q  <= 2'd0;
			last_q <= in_last;
		end else if (cmd.advance) begin
			pos_q <= pos_q + adv;
			if (!stat.drop)
				lead_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			buf_q[0] <= buf_n[0];
			buf_q[1] <= buf_n[1];
			buf_q[2] <= buf_n[2];
		end
	end

	// whitespace run: shift line popped at entry zero
	assign push_idx = cmd.run_pop ? RUN_TOP : run_cnt_q[utf8pn_pkg::RUN_IDX_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.run_pop) begin
			for (int i = 0; i < utf8pn_pkg::RUN_DEPTH - 1; i++)
				run_q[i] <= run_q[i+1];
		end
		if (cmd.run_push)
			run_q[push_idx] <= ws[1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			run_cnt_q <= '0;
		else if (cmd.clear)
			run_cnt_q <= '0;
		else if (cmd.run_push && !cmd.run_pop)
			run_cnt_q <= run_cnt_q + utf8pn_pkg::RUN_CNT_W'(1);
		else if (cmd.run_pop && !cmd.run_push)
			run_cnt_q <= run_cnt_q - utf8pn_pkg::RUN_CNT_W'(1);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit != utf8pn_pkg::EM_NONE)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit != utf8pn_pkg::EM_NONE) begin
			out_has_q  <= (cmd.emit != utf8pn_pkg::EM_END);
			out_last_q <= (cmd.emit == utf8pn_pkg::EM_END);
			out_ovf_q  <= (cmd.emit == utf8pn_pkg::EM_OVF);
			unique case (cmd.emit)
				utf8pn_pkg::EM_SYM: out_byte_q <= sym;
				utf8pn_pkg::EM_RUN,
				utf8pn_pkg::EM_OVF: out_byte_q <= utf8pn_pkg::ws_char(run_q[0]);
				default:            out_byte_q <= 8'h00;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_has   = out_has_q;
	assign out_last  = out_last_q;
	assign out_ovf   = out_ovf_q;

endmodule

FILE: design/utf8_punct_normalize_trim_top.sv
// ============================================================================
// utf8_punct_normalize_trim_top: UTF-8 punctuation folding and trimming
// Folds curly quotes, primes, dashes and no-break space to ASCII, strips
// leading ASCII non-letters and drops trailing whitespace at end of stream.
// ============================================================================
// Each input byte is loaded into the buffer and then handled by parser steps;
// a new byte is taken only once the buffered bytes are done, or a lead byte
// waits for its sequence. Held whitespace is released from the flush state,
// the end marker from the end state, both through the output register.
// Reset: arst_n clears parser position, run count, leading phase and output
// valid at once; no clearing pass, the block is ready right after reset.
module utf8_punct_normalize_trim_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_byte
	input  logic       s_tlast,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic [1:0] m_tuser,   // [0] has_byte, [1] ws_overflow
	output logic       m_tlast
);

	utf8pn_pkg::cmd_t  cmd;
	utf8pn_pkg::stat_t stat;

	utf8pn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	utf8pn_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_byte   (s_tdata),
		.in_last   (s_tlast),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_byte  (m_tdata),
		.out_has   (m_tuser[0]),
		.out_last  (m_tlast),
		.out_ovf   (m_tuser[1])
	);

endmodule
